[sv/se2pci_pkg.sv]
// se2pci_pkg: shared widths, item types and operation codes for the SE(2) pose block.
// No dependencies; every other file refers to it by scoped names.
package se2pci_pkg;

    localparam int POS_WIDTH    = 32;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_ITERS = 28;
    localparam int ITER_W       = 5;
    localparam int TRIG_FRAC    = 30;
    localparam int TRIG_W       = 33;
    localparam int Z_W          = 34;
    localparam int TURN_W       = 32;
    localparam int GAIN_INV     = 652032874;
    localparam int MAG_T_W      = 31;
    localparam int PROD_W       = POS_WIDTH + MAG_T_W;
    localparam int RND_W        = PROD_W - TRIG_FRAC + 1;
    localparam int TERM_W       = RND_W + 1;
    localparam int SUM_W        = TERM_W + 2;

    typedef enum logic [1:0] {
        OP_COMPOSE = 2'd0,
        OP_INVERSE = 2'd1,
        OP_BETWEEN = 2'd2,
        OP_PASS    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic signed [POS_WIDTH-1:0]   a_x;
        logic signed [POS_WIDTH-1:0]   a_y;
        logic signed [ANGLE_WIDTH-1:0] a_heading;
        logic signed [POS_WIDTH-1:0]   b_x;
        logic signed [POS_WIDTH-1:0]   b_y;
        logic signed [ANGLE_WIDTH-1:0] b_heading;
    } req_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0]   out_x;
        logic signed [POS_WIDTH-1:0]   out_y;
        logic signed [ANGLE_WIDTH-1:0] out_heading;
        logic                          saturated;
    } rsp_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [Z_W-1:0]    z;
        logic [1:0]               q;
    } lane_t;

    typedef struct packed {
        logic  valid;
        req_t  item;
        lane_t lane0;
        lane_t lane1;
    } cell_bus_t;

    typedef struct packed {
        logic                        inv;
        logic signed [POS_WIDTH-1:0] base_x;
        logic signed [POS_WIDTH-1:0] base_y;
        logic signed [POS_WIDTH-1:0] vec_x;
        logic signed [POS_WIDTH-1:0] vec_y;
        logic signed [TRIG_W-1:0]    c;
        logic signed [TRIG_W-1:0]    s;
    } pose_op_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] x;
        logic signed [POS_WIDTH-1:0] y;
        logic                        sat;
    } pose_res_t;

endpackage

[sv/se2_pose_compose_invert.sv]
// se2_pose_compose_invert: SE(2) compose / inverse / between, fully pipelined.
// Depends on se2pci_pkg, se2pci_cordic_cell, se2pci_pose_unit.
//
//  channel   ports              handshake
//  --------  -----------------  ----------------------------------------------
//  request   start, busy, req   item taken on a rising edge with start && !busy
//  result    done, rsp          rsp valid for the single cycle done is high
//
// One item may enter every cycle; busy is always low. An item passes through
// the 28 CORDIC cells (one rotation each, both headings side by side), the
// first pose unit (multiply, then round/sum/clamp), the second pose unit and
// one output register. Reset clears only the valid bits along the chain.
// The receiver cannot stall, so nothing ever backs up.
module se2_pose_compose_invert (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  se2pci_pkg::req_t   req,
    output logic               done,
    output se2pci_pkg::rsp_t   rsp
);

    localparam int N  = se2pci_pkg::CORDIC_ITERS;
    localparam int AW = se2pci_pkg::ANGLE_WIDTH;
    localparam int TW = se2pci_pkg::TURN_W;

    typedef struct packed {
        logic signed [se2pci_pkg::TRIG_W-1:0] c;
        logic signed [se2pci_pkg::TRIG_W-1:0] s;
    } trig_t;

    // widen heading to a full-turn binary angle, split off nearest quarter turn
    function automatic se2pci_pkg::lane_t lane_init(input logic [AW-1:0] h);
        logic [TW-1:0]     a;
        logic [TW-1:0]     r;
        logic [1:0]        q;
        se2pci_pkg::lane_t l;
        a   = {h, {(TW-AW){1'b0}}};
        q   = 2'((a + (TW'(1) << (TW-3))) >> (TW-2));
        r   = a - {q, {(TW-2){1'b0}}};
        l.x = se2pci_pkg::TRIG_W'(se2pci_pkg::GAIN_INV);
        l.y = '0;
        l.z = se2pci_pkg::Z_W'($signed(r));
        l.q = q;
        return l;
    endfunction

    // apply the quarter turns exactly
    function automatic trig_t trig_map(input se2pci_pkg::lane_t l);
        trig_t t;
        unique case (l.q)
            2'd0:
            begin
                t.c = l.x;
                t.s = l.y;
            end
            2'd1:
            begin
                t.c = -l.y;
                t.s = l.x;
            end
            2'd2:
            begin
                t.c = -l.x;
                t.s = -l.y;
            end
            default:
            begin
                t.c = l.y;
                t.s = -l.x;
            end
        endcase
        return t;
    endfunction

    se2pci_pkg::cell_bus_t chain [N+1];

    assign busy = 1'b0;

    always_comb
    begin
        chain[0].valid = start;
        chain[0].item  = req;
        chain[0].lane0 = lane_init(req.a_heading);
        // the between operation's second stage rotates by the negated heading
        chain[0].lane1 = lane_init(AW'(-req.a_heading));
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        se2pci_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .iter  (se2pci_pkg::ITER_W'(g)),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    se2pci_pkg::cell_bus_t tail;
    trig_t                 trig0;
    trig_t                 trig1;
    se2pci_pkg::op_t       tail_op;
    se2pci_pkg::pose_op_t  op1;
    se2pci_pkg::pose_res_t res1;

    assign tail    = chain[N];
    assign trig0   = trig_map(tail.lane0);
    assign trig1   = trig_map(tail.lane1);
    assign tail_op = se2pci_pkg::op_t'(tail.item.req_type);

    // first unit: compose A then B, or the inverse of A
    always_comb
    begin
        op1.inv = (tail_op != se2pci_pkg::OP_COMPOSE);
        op1.c   = trig0.c;
        op1.s   = trig0.s;
        if (op1.inv)
        begin
            op1.base_x = '0;
            op1.base_y = '0;
            op1.vec_x  = tail.item.a_x;
            op1.vec_y  = tail.item.a_y;
        end
        else
        begin
            op1.base_x = tail.item.a_x;
            op1.base_y = tail.item.a_y;
            op1.vec_x  = tail.item.b_x;
            op1.vec_y  = tail.item.b_y;
        end
    end

    se2pci_pose_unit u_pose1 (
        .clk (clk),
        .op  (op1),
        .res (res1)
    );

    // side band alongside the first unit
    logic             d1_valid_reg [2];
    se2pci_pkg::req_t d1_item_reg  [2];
    trig_t            d1_trig_reg  [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg[0] <= 1'b0;
            d1_valid_reg[1] <= 1'b0;
        end
        else
        begin
            d1_valid_reg[0] <= tail.valid;
            d1_valid_reg[1] <= d1_valid_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        d1_item_reg[0] <= tail.item;
        d1_item_reg[1] <= d1_item_reg[0];
        d1_trig_reg[0] <= trig1;
        d1_trig_reg[1] <= d1_trig_reg[0];
    end

    // second unit: inverse of A (already clamped) composed with B
    se2pci_pkg::pose_op_t  op2;
    se2pci_pkg::pose_res_t res2;

    always_comb
    begin
        op2.inv    = 1'b0;
        op2.base_x = res1.x;
        op2.base_y = res1.y;
        op2.vec_x  = d1_item_reg[1].b_x;
        op2.vec_y  = d1_item_reg[1].b_y;
        op2.c      = d1_trig_reg[1].c;
        op2.s      = d1_trig_reg[1].s;
    end

    se2pci_pose_unit u_pose2 (
        .clk (clk),
        .op  (op2),
        .res (res2)
    );

    logic                  d2_valid_reg [2];
    se2pci_pkg::req_t      d2_item_reg  [2];
    se2pci_pkg::pose_res_t d2_res_reg   [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d2_valid_reg[0] <= 1'b0;
            d2_valid_reg[1] <= 1'b0;
        end
        else
        begin
            d2_valid_reg[0] <= d1_valid_reg[1];
            d2_valid_reg[1] <= d2_valid_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        d2_item_reg[0] <= d1_item_reg[1];
        d2_item_reg[1] <= d2_item_reg[0];
        d2_res_reg[0]  <= res1;
        d2_res_reg[1]  <= d2_res_reg[0];
    end

    // final selection; headings wrap in two's complement
    se2pci_pkg::req_t fin;
    se2pci_pkg::rsp_t rsp_next;
    se2pci_pkg::rsp_t rsp_reg;
    logic             done_reg;

    assign fin = d2_item_reg[1];

    always_comb
    begin
        unique case (se2pci_pkg::op_t'(fin.req_type))
            se2pci_pkg::OP_COMPOSE:
            begin
                rsp_next.out_x       = d2_res_reg[1].x;
                rsp_next.out_y       = d2_res_reg[1].y;
                rsp_next.out_heading = AW'(fin.a_heading + fin.b_heading);
                rsp_next.saturated   = d2_res_reg[1].sat;
            end
            se2pci_pkg::OP_INVERSE:
            begin
                rsp_next.out_x       = d2_res_reg[1].x;
                rsp_next.out_y       = d2_res_reg[1].y;
                rsp_next.out_heading = AW'(-fin.a_heading);
                rsp_next.saturated   = d2_res_reg[1].sat;
            end
            se2pci_pkg::OP_BETWEEN:
            begin
                rsp_next.out_x       = res2.x;
                rsp_next.out_y       = res2.y;
                rsp_next.out_heading = AW'(fin.b_heading - fin.a_heading);
                rsp_next.saturated   = d2_res_reg[1].sat | res2.sat;
            end
            default:
            begin
                // unused code: A passes straight through
                rsp_next.out_x       = fin.a_x;
                rsp_next.out_y       = fin.a_y;
                rsp_next.out_heading = fin.a_heading;
                rsp_next.saturated   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d2_valid_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[sv/se2pci_cordic_cell.sv]
// se2pci_cordic_cell: one CORDIC rotation for two heading lanes, registered.
// Depends on se2pci_pkg.
module se2pci_cordic_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [se2pci_pkg::ITER_W-1:0] iter,
    input  se2pci_pkg::cell_bus_t        din,
    output se2pci_pkg::cell_bus_t        dout
);

    function automatic logic [31:0] atan_entry(input logic [se2pci_pkg::ITER_W-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic se2pci_pkg::lane_t rotate(input se2pci_pkg::lane_t l,
                                                 input logic [se2pci_pkg::ITER_W-1:0] i);
        logic signed [se2pci_pkg::TRIG_W-1:0] xs;
        logic signed [se2pci_pkg::TRIG_W-1:0] ys;
        logic signed [se2pci_pkg::Z_W-1:0]    da;
        se2pci_pkg::lane_t                    r;
        xs = l.x >>> i;
        ys = l.y >>> i;
        da = signed'(se2pci_pkg::Z_W'(atan_entry(i)));
        r  = l;
        // zero residue rotates positive
        if (!l.z[se2pci_pkg::Z_W-1])
        begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - da;
        end
        else
        begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + da;
        end
        return r;
    endfunction

    logic                  valid_reg;
    se2pci_pkg::req_t      item_reg;
    se2pci_pkg::lane_t     lane0_reg;
    se2pci_pkg::lane_t     lane1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= din.item;
        lane0_reg <= rotate(din.lane0, iter);
        lane1_reg <= rotate(din.lane1, iter);
    end

    assign dout.valid = valid_reg;
    assign dout.item  = item_reg;
    assign dout.lane0 = lane0_reg;
    assign dout.lane1 = lane1_reg;

endmodule

[sv/se2pci_pose_unit.sv]
// se2pci_pose_unit: rotate a position by (c, s), add a base, clamp; two register stages.
// Depends on se2pci_pkg.
module se2pci_pose_unit (
    input  logic                     clk,
    input  se2pci_pkg::pose_op_t     op,
    output se2pci_pkg::pose_res_t    res
);

    localparam int PW = se2pci_pkg::POS_WIDTH;
    localparam int SW = se2pci_pkg::SUM_W;
    localparam logic signed [SW-1:0] MAX_POS = {{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_POS = ~MAX_POS;

    function automatic logic [PW-1:0] mag_v(input logic signed [PW-1:0] v);
        logic [PW:0] e;
        e = v[PW-1] ? (PW+1)'(-$signed({v[PW-1], v})) : (PW+1)'({v[PW-1], v});
        return e[PW-1:0];
    endfunction

    function automatic logic [se2pci_pkg::MAG_T_W-1:0] mag_t(
        input logic signed [se2pci_pkg::TRIG_W-1:0] t);
        logic [se2pci_pkg::TRIG_W-1:0] m;
        m = t[se2pci_pkg::TRIG_W-1] ? se2pci_pkg::TRIG_W'(-t) : se2pci_pkg::TRIG_W'(t);
        if (m[se2pci_pkg::TRIG_W-1:se2pci_pkg::MAG_T_W] != '0)
            return '1;
        return m[se2pci_pkg::MAG_T_W-1:0];
    endfunction

    function automatic logic signed [se2pci_pkg::TERM_W-1:0] round_term(
        input logic [se2pci_pkg::PROD_W-1:0] p, input logic neg);
        logic [se2pci_pkg::PROD_W:0]            a;
        logic [se2pci_pkg::RND_W-1:0]           r;
        logic signed [se2pci_pkg::TERM_W-1:0]   t;
        a = {1'b0, p} + ((se2pci_pkg::PROD_W+1)'(1) << (se2pci_pkg::TRIG_FRAC-1));
        r = a[se2pci_pkg::PROD_W:se2pci_pkg::TRIG_FRAC];
        t = $signed({1'b0, r});
        return neg ? -t : t;
    endfunction

    function automatic logic signed [PW-1:0] clamp(input logic signed [SW-1:0] v,
                                                   output logic hit);
        hit = 1'b0;
        if (v > MAX_POS)
        begin
            hit = 1'b1;
            return MAX_POS[PW-1:0];
        end
        if (v < MIN_POS)
        begin
            hit = 1'b1;
            return MIN_POS[PW-1:0];
        end
        return v[PW-1:0];
    endfunction

    // products: 0 x*c, 1 y*s, 2 x*s, 3 y*c
    logic [se2pci_pkg::PROD_W-1:0] prod_next [4];
    logic [3:0]                    neg_next;
    logic [se2pci_pkg::PROD_W-1:0] prod_reg [4];
    logic [3:0]                    neg_reg;
    logic signed [PW-1:0]          base_x_reg;
    logic signed [PW-1:0]          base_y_reg;
    se2pci_pkg::pose_res_t         res_reg;
    se2pci_pkg::pose_res_t         res_next;

    always_comb
    begin
        logic [PW-1:0]                    mx;
        logic [PW-1:0]                    my;
        logic [se2pci_pkg::MAG_T_W-1:0]   mc;
        logic [se2pci_pkg::MAG_T_W-1:0]   ms;
        logic                             sx;
        logic                             sy;
        logic                             sc;
        logic                             ss;
        mx = mag_v(op.vec_x);
        my = mag_v(op.vec_y);
        mc = mag_t(op.c);
        ms = mag_t(op.s);
        sx = op.vec_x[PW-1];
        sy = op.vec_y[PW-1];
        sc = op.c[se2pci_pkg::TRIG_W-1];
        ss = op.s[se2pci_pkg::TRIG_W-1];
        prod_next[0] = se2pci_pkg::PROD_W'(mx) * se2pci_pkg::PROD_W'(mc);
        prod_next[1] = se2pci_pkg::PROD_W'(my) * se2pci_pkg::PROD_W'(ms);
        prod_next[2] = se2pci_pkg::PROD_W'(mx) * se2pci_pkg::PROD_W'(ms);
        prod_next[3] = se2pci_pkg::PROD_W'(my) * se2pci_pkg::PROD_W'(mc);
        // x' = bx +- x*c - y*s ; y' = by + x*s +- y*c (minus on the inverse)
        neg_next[0] = sx ^ sc ^ op.inv;
        neg_next[1] = sy ^ ss ^ 1'b1;
        neg_next[2] = sx ^ ss;
        neg_next[3] = sy ^ sc ^ op.inv;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_reg[k] <= prod_next[k];
        end
        neg_reg    <= neg_next;
        base_x_reg <= op.base_x;
        base_y_reg <= op.base_y;
        res_reg    <= res_next;
    end

    always_comb
    begin
        logic signed [SW-1:0] sum_x;
        logic signed [SW-1:0] sum_y;
        logic                 hx;
        logic                 hy;
        sum_x = SW'(base_x_reg) + SW'(round_term(prod_reg[0], neg_reg[0]))
              + SW'(round_term(prod_reg[1], neg_reg[1]));
        sum_y = SW'(base_y_reg) + SW'(round_term(prod_reg[2], neg_reg[2]))
              + SW'(round_term(prod_reg[3], neg_reg[3]));
        res_next.x   = clamp(sum_x, hx);
        res_next.y   = clamp(sum_y, hy);
        res_next.sat = hx | hy;
    end

    assign res = res_reg;

endmodule

[sv/se2pci_top_note.sv]
// se2pci_top_note is not used: see se2pci_pose_unit and the top level.

[dv/se2_pose_checker.sv]
`timescale 1ns / 100ps
// se2_pose_checker: watches the request and result channels of se2_pose_compose_invert,
// predicts each pose result and compares it field by field. Depends on se2pci_pkg.
module se2_pose_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  se2pci_pkg::req_t req,
    input  logic             done,
    input  se2pci_pkg::rsp_t rsp,
    output int               fail_count,
    output int               pending
);

    localparam logic [31:0] ATAN_LUT [0:27] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5};

    se2pci_pkg::rsp_t expected_poses[$];

    // cos/sin in Q2.30 of a binary-angle heading
    function automatic void heading_trig(input logic [15:0] hd, output longint c,
                                         output longint s);
        logic [31:0] a32, r32;
        logic [1:0]  q;
        longint      z, x, y, nx;
        a32 = {hd, 16'h0};
        q   = 2'((a32 + 32'h2000_0000) >> 30);
        r32 = a32 - {q, 30'h0};
        z   = longint'($signed(r32));
        x   = se2pci_pkg::GAIN_INV;
        y   = 0;
        for (int i = 0; i < se2pci_pkg::CORDIC_ITERS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_LUT[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_LUT[i]);
            end
            x = nx;
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // position times trig value, rounded half away from zero
    function automatic logic signed [127:0] scale_by_trig(longint v, longint t);
        logic [127:0] mv, mt, mag;
        mv = (v < 0) ? 128'(-v) : 128'(v);
        mt = (t < 0) ? 128'(-t) : 128'(t);
        if (mt > 128'h7FFF_FFFF)
            mt = 128'h7FFF_FFFF;
        mag = (mv * mt + (128'd1 << 29)) >> 30;
        return ((v < 0) != (t < 0)) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [31:0] clip_pos(logic signed [127:0] w, inout logic sat);
        if (w > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (w < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return w[31:0];
    endfunction

    function automatic void compose_pose(input logic signed [31:0] ax, ay,
                                         input logic [15:0] ah,
                                         input logic signed [31:0] bx, by,
                                         input logic [15:0] bh,
                                         inout logic sat,
                                         output logic signed [31:0] rx, ry,
                                         output logic [15:0] rh);
        longint c, s;
        heading_trig(ah, c, s);
        rx = clip_pos(128'(ax) + scale_by_trig(bx, c) - scale_by_trig(by, s), sat);
        ry = clip_pos(128'(ay) + scale_by_trig(bx, s) + scale_by_trig(by, c), sat);
        rh = ah + bh;
    endfunction

    function automatic void invert_pose(input logic signed [31:0] px, py,
                                        input logic [15:0] ph,
                                        inout logic sat,
                                        output logic signed [31:0] rx, ry,
                                        output logic [15:0] rh);
        longint c, s;
        heading_trig(ph, c, s);
        rx = clip_pos(-scale_by_trig(px, c) - scale_by_trig(py, s), sat);
        ry = clip_pos(scale_by_trig(px, s) - scale_by_trig(py, c), sat);
        rh = -ph;
    endfunction

    function automatic se2pci_pkg::rsp_t predict_pose(se2pci_pkg::req_t r);
        se2pci_pkg::rsp_t   p;
        logic               sat;
        logic signed [31:0] ix, iy, ox, oy;
        logic [15:0]        ih, oh;
        sat = 1'b0;
        case (se2pci_pkg::op_t'(r.req_type))
            se2pci_pkg::OP_COMPOSE:
                compose_pose(r.a_x, r.a_y, r.a_heading, r.b_x, r.b_y, r.b_heading,
                             sat, ox, oy, oh);
            se2pci_pkg::OP_INVERSE:
                invert_pose(r.a_x, r.a_y, r.a_heading, sat, ox, oy, oh);
            se2pci_pkg::OP_BETWEEN:
            begin
                invert_pose(r.a_x, r.a_y, r.a_heading, sat, ix, iy, ih);
                compose_pose(ix, iy, ih, r.b_x, r.b_y, r.b_heading, sat, ox, oy, oh);
            end
            default:
            begin
                ox = r.a_x;
                oy = r.a_y;
                oh = r.a_heading;
            end
        endcase
        p.out_x       = ox;
        p.out_y       = oy;
        p.out_heading = oh;
        p.saturated   = sat;
        return p;
    endfunction

    assign pending = expected_poses.size();

    always @(posedge clk or negedge rst_n)
    begin
        se2pci_pkg::rsp_t exp_p;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_poses.size() == 0)
                begin
                    $error("result with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_p = expected_poses.pop_front();
                    if (exp_p !== rsp)
                    begin
                        if (exp_p.out_x !== rsp.out_x)
                            $error("out_x exp %0d got %0d", exp_p.out_x, rsp.out_x);
                        if (exp_p.out_y !== rsp.out_y)
                            $error("out_y exp %0d got %0d", exp_p.out_y, rsp.out_y);
                        if (exp_p.out_heading !== rsp.out_heading)
                            $error("out_heading exp %0d got %0d",
                                   exp_p.out_heading, rsp.out_heading);
                        if (exp_p.saturated !== rsp.saturated)
                            $error("saturated exp %0b got %0b",
                                   exp_p.saturated, rsp.saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_poses.insert(expected_poses.size(), predict_pose(req));
        end
    end
endmodule

[dv/se2_pose_compose_invert_tb.sv]
`timescale 1ns / 100ps
// se2_pose_compose_invert_tb: stimulus and verdict for se2_pose_compose_invert.
// Depends on se2pci_pkg, the block and se2_pose_checker.
module se2_pose_compose_invert_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    se2pci_pkg::req_t req;
    logic             done;
    se2pci_pkg::rsp_t rsp;
    int               fail_count;
    int               pending;
    int               idle_pct;
    int               stall_count;

    se2_pose_compose_invert DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    se2_pose_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: cycles with neither an item taken nor a result given.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT)
        begin
            $display("se2_pose_compose_invert_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic logic [15:0] pick_heading();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(16'h2000 * $urandom_range(0, 7));
            default: return 16'($urandom());
        endcase
    endfunction

    // Present one item and hold it until taken; idling between items per phase.
    task automatic send_item(input se2pci_pkg::req_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random(input int n);
        se2pci_pkg::req_t it;
        for (int i = 0; i < n; i++)
        begin
            it.req_type  = ($urandom_range(0, 19) == 0) ? se2pci_pkg::OP_PASS
                                                        : 2'($urandom_range(0, 2));
            it.a_x       = pick_pos();
            it.a_y       = pick_pos();
            it.a_heading = pick_heading();
            it.b_x       = pick_pos();
            it.b_y       = pick_pos();
            it.b_heading = pick_heading();
            send_item(it);
        end
    endtask

    initial
    begin
        se2pci_pkg::req_t it;
        int               guard;
        rst_n    = 1'b0;
        start    = 1'b0;
        req      = '0;
        idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation at the field extremes, minimum heading
        // negation, saturating positions and the unused code passing A through.
        for (int op = 0; op < 4; op++)
        begin
            it = '{op[1:0], 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF};
            send_item(it);
            it = '{op[1:0], 32'h8000_0000, 32'h7FFF_FFFF, 16'h4000,
                   32'h8000_0000, 32'h8000_0000, 16'h8000};
            send_item(it);
            it = '{op[1:0], 32'h0001_0000, 32'hFFFF_0000, 16'h0000,
                   32'h0002_0000, 32'h0, 16'hC000};
            send_item(it);
            it = '{op[1:0], 32'h0, 32'h0, 16'h2000, 32'h0000_8000, 32'hFFFF_8000, 16'h1000};
            send_item(it);
            it = '{op[1:0], 32'hFFFF_FFFF, 32'h1, 16'hE000, 32'h1, 32'hFFFF_FFFF, 16'h8001};
            send_item(it);
        end

        // Random phases: no idling, heavy sender idling, the mixed rate, no idling again.
        idle_pct = 0;
        send_random(340);
        idle_pct = 64;
        send_random(340);
        idle_pct = 22;
        send_random(340);
        idle_pct = 0;
        send_random(310);
        start <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("se2_pose_compose_invert_tb: done, clean");
        else
            $display("se2_pose_compose_invert_tb: done, errors");
        $finish;
    end
endmodule
